[rtl/core/ptig_pkg.sv]
// shared types, emission pattern codes and index functions for the index generator
package ptig_pkg;

  localparam int unsigned IDX_W = 16;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned PAT_W = 3;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  localparam logic [KIND_W-1:0] KIND_QUADS  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TRIS   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STRIP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LINES  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LSTRIP = 3'd5;
  localparam logic [KIND_W-1:0] KIND_POINTS = 3'd6;

  // emission patterns as handed from the front to the back
  localparam logic [PAT_W-1:0] PAT_NONE       = 3'd0;
  localparam logic [PAT_W-1:0] PAT_SINGLE     = 3'd1;
  localparam logic [PAT_W-1:0] PAT_QUAD       = 3'd2;
  localparam logic [PAT_W-1:0] PAT_STRIP_EVEN = 3'd3;
  localparam logic [PAT_W-1:0] PAT_STRIP_ODD  = 3'd4;
  localparam logic [PAT_W-1:0] PAT_FAN        = 3'd5;
  localparam logic [PAT_W-1:0] PAT_PAIR       = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] primitive_req;
    logic [IDX_W-1:0]  base_index;
    logic [IDX_W-1:0]  vertex_number;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             run_end;
  } out_item_t;

  typedef struct packed {
    logic [PAT_W-1:0] pat;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CNT_W-1:0] pat_len(input logic [PAT_W-1:0] pat);
    logic [CNT_W-1:0] n;
    case (pat)
      PAT_SINGLE:     n = 3'd1;
      PAT_QUAD:       n = 3'd6;
      PAT_STRIP_EVEN: n = 3'd3;
      PAT_STRIP_ODD:  n = 3'd3;
      PAT_FAN:        n = 3'd3;
      PAT_PAIR:       n = 3'd2;
      default:        n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] pat_index(input logic [PAT_W-1:0] pat,
                                                 input logic [CNT_W-1:0] k,
                                                 input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] m1;
    logic [IDX_W-1:0] m2;
    logic [IDX_W-1:0] m3;
    logic [IDX_W-1:0] r;
    m1 = idx - IDX_W'(1);
    m2 = idx - IDX_W'(2);
    m3 = idx - IDX_W'(3);
    r = idx;
    case (pat)
      PAT_QUAD: begin
        case (k)
          3'd0:    r = m3;
          3'd1:    r = m2;
          3'd2:    r = m1;
          3'd3:    r = m1;
          3'd4:    r = idx;
          default: r = m3;
        endcase
      end
      PAT_STRIP_EVEN: begin
        case (k)
          3'd0:    r = m2;
          3'd1:    r = m1;
          default: r = idx;
        endcase
      end
      PAT_STRIP_ODD: begin
        case (k)
          3'd0:    r = m1;
          3'd1:    r = m2;
          default: r = idx;
        endcase
      end
      PAT_FAN: begin
        case (k)
          3'd0:    r = base;
          3'd1:    r = m1;
          default: r = idx;
        endcase
      end
      PAT_PAIR: begin
        r = (k == 3'd0) ? m1 : idx;
      end
      default: r = idx;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ptig_front.sv]
// front end: classifies each vertex into an emission pattern and pushes those that emit indices to the queue
module ptig_front (
  input  ptig_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptig_pkg::q_status_t q_stat,
  output logic                q_push,
  output ptig_pkg::q_entry_t  q_wdata
);
  import ptig_pkg::*;

  logic [PAT_W-1:0] pat;
  logic             v_small;
  logic             v_odd;

  assign v_small = (in_data.vertex_number < IDX_W'(3));
  assign v_odd   = in_data.vertex_number[0];

  always_comb begin
    case (in_data.primitive_req)
      KIND_QUADS:  pat = (in_data.vertex_number[1:0] == 2'd3) ? PAT_QUAD : PAT_NONE;
      KIND_TRIS:   pat = PAT_SINGLE;
      KIND_POINTS: pat = PAT_SINGLE;
      KIND_STRIP:  pat = v_small ? PAT_SINGLE : (v_odd ? PAT_STRIP_ODD : PAT_STRIP_EVEN);
      KIND_FAN:    pat = v_small ? PAT_SINGLE : PAT_FAN;
      KIND_LINES:  pat = v_odd ? PAT_PAIR : PAT_NONE;
      KIND_LSTRIP: pat = (in_data.vertex_number != '0) ? PAT_PAIR : PAT_NONE;
      default:     pat = PAT_NONE;
    endcase
  end

  // a vertex that emits nothing is taken and dropped here
  assign in_stall     = q_stat.full;
  assign q_push       = in_valid && !q_stat.full && (pat != PAT_NONE);
  assign q_wdata.pat  = pat;
  assign q_wdata.base = in_data.base_index;
  assign q_wdata.idx  = in_data.base_index + in_data.vertex_number;

endmodule

[rtl/core/ptig_queue.sv]
// two-entry queue between the classifier and the index sequencer
module ptig_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptig_pkg::q_entry_t  wdata,
  input  logic                pop,
  output ptig_pkg::q_entry_t  head,
  output ptig_pkg::q_status_t stat
);
  import ptig_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/ptig_back.sv]
// back end: walks the head pattern, one index per unstalled cycle, to the output register
module ptig_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ptig_pkg::q_entry_t  head,
  input  ptig_pkg::q_status_t q_stat,
  output logic                q_pop,
  output ptig_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_stall
);
  import ptig_pkg::*;

  logic [CNT_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             adv;
  logic             load;
  logic             last;

  assign adv  = !out_valid_r || !out_stall;
  assign load = adv && !q_stat.empty;
  assign last = (k_r == pat_len(head.pat) - CNT_W'(1));
  assign q_pop = load && last;

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt = load;
    end
    if (load) begin
      out_data_nxt.index   = pat_index(head.pat, k_r, head.base, head.idx);
      out_data_nxt.run_end = last;
      k_nxt                = last ? '0 : k_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (k_r < pat_len(head.pat)))
    else $error("step counter beyond pattern length");
  a_k_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> (k_r == '0))
    else $error("step counter not cleared with empty queue");
  a_k_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(k_r))
    else $error("sequencer advanced while output stalled");
  a_pop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_data_r.run_end))
    else $error("queue entry retired without run end");
`endif

endmodule

[rtl/core/primitive_topology_index_generator_core.sv]
// Primitive assembly index generator. Each vertex is classified on arrival and
// queued (two entries); the sequencer then emits its indices one per cycle
// through a registered output while the output is not stalled. A vertex
// emits six indices if it closes a quad, three if it is a strip or fan
// vertex past the first three, two for line pairs, one for triangles and
// points, and none if it completes nothing; such vertices are taken
// without occupying the back end. The output index rate of one per cycle
// sets throughput, so fan and strip draws are bounded by three indices per
// vertex. Indices wrap modulo 2^16; run_end marks a vertex's last index.
module primitive_topology_index_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  ptig_pkg::in_item_t  in_data,
  input  logic                in_valid,
  output logic                in_stall,
  output ptig_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_stall
);
  import ptig_pkg::*;

  q_status_t q_stat;
  q_entry_t  q_wdata;
  q_entry_t  q_head;
  logic      q_push;
  logic      q_pop;

  ptig_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  ptig_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  ptig_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
